// File: rtl/core/multicast_replier_selector_core_macros.svh
// assertion macros shared by the replier selector rtl
`ifndef MULTICAST_REPLIER_SELECTOR_CORE_MACROS_SVH
`define MULTICAST_REPLIER_SELECTOR_CORE_MACROS_SVH

// same-cycle implication on the block clock, off during reset
`define MRS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the block clock, off during reset
`define MRS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/mrs_pkg.sv
package mrs_pkg;

   // default number of router interfaces
   localparam int IFACE_COUNT_DEF = 1024;

   // replier cost that stands for infinity
   localparam logic [19:0] COST_INFINITY = 20'd1000000;

   localparam int REQ_TDATA_W = 224;
   localparam int RSP_TDATA_W = 168;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   // packet type carried in the request tuser
   typedef enum logic [2:0] {
      MODE_SRC_REFRESH = 3'd0,
      MODE_REFRESH     = 3'd1,
      MODE_REQUEST     = 3'd2,
      MODE_DMCAST      = 3'd3,
      MODE_LEAVE       = 3'd4,
      MODE_SETUP       = 3'd5,
      MODE_SPM         = 3'd6,
      MODE_LINKS       = 3'd7
   } mode_type;

   // forwarding action
   typedef enum logic [2:0] {
      ACT_NEXT  = 3'd0,
      ACT_UP    = 3'd1,
      ACT_DOWN  = 3'd2,
      ACT_LOCAL = 3'd3,
      ACT_LINK  = 3'd4,
      ACT_DROP  = 3'd5,
      ACT_ERROR = 3'd6
   } action_type;

   // kind of the chosen replier
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_LOCAL = 2'd1,
      KIND_LINK  = 2'd2
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_AGENT_ENABLE = 2'd0,
      CSR_OWN_ADDRESS  = 2'd1,
      CSR_OWN_PORT     = 2'd2
   } csr_index_type;

   // request beat, first field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [15:0]        src_port;
      logic signed [31:0] src_addr;
      logic [9:0]         tp_iface;
      logic signed [31:0] path_addr;
      logic signed [31:0] tp_addr;
      logic signed [16:0] carried_down_port;
      logic signed [31:0] carried_down_addr;
      logic [7:0]         ttl;
      logic [7:0]         hop_count;
      logic [19:0]        adv_cost;
      logic signed [10:0] in_iface;
   } req_fields_type;

   // result beat, first field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic               tree_link;
      logic               tp_fill;
      logic signed [16:0] down_port_out;
      logic signed [31:0] down_addr_out;
      logic signed [31:0] from_out;
      logic [7:0]         ttl_out;
      logic [7:0]         hop_count_out;
      logic signed [16:0] dest_port;
      logic signed [31:0] dest_addr;
      logic signed [10:0] out_iface;
      action_type         action;
   } rsp_fields_type;

endpackage

// File: rtl/core/multicast_replier_selector_core.sv
// Replier selector for light-weight reliable multicast: one control packet
// summary per request beat (packet type in tuser), one forwarding action per
// result beat. A beat is captured in an input register, then the agent state
// (replier, upstream, downstream agent, receiver flag) is read, updated and the
// rewritten header is written into the result register as the beat moves on;
// a new beat is taken every cycle while the result register is free or its
// result is taken. While a result waits one more beat is still taken into the
// input register; the input stalls only when both registers hold a beat and
// the result is not taken. Configuration must be written through
// csr_we/csr_index/csr_wdata only while no beat is in flight; the block
// itself does not enforce this.
`include "multicast_replier_selector_core_macros.svh"

module multicast_replier_selector_core #(
   parameter int IFACE_COUNT = mrs_pkg::IFACE_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // in_iface, adv_cost, hop_count, ttl, carried_down_addr, carried_down_port,
   // tp_addr, path_addr, tp_iface, src_addr, src_port
   input  logic [mrs_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // mode
   input  logic [2:0]                           req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // action, out_iface, dest_addr, dest_port, hop_count_out, ttl_out, from_out,
   // down_addr_out, down_port_out, tp_fill, tree_link
   output logic [mrs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [mrs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mrs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration
   logic        agent_enable_ff;
   logic [30:0] own_address_ff;
   logic [15:0] own_port_ff;

   // pipeline
   logic                    in_valid_ff;
   mrs_pkg::req_fields_type in_data_ff;
   mrs_pkg::mode_type       in_mode_ff;
   logic                    out_valid_ff;
   mrs_pkg::rsp_fields_type out_data_ff;
   mrs_pkg::rsp_fields_type res_in;
   logic                    advance;

   // agent state
   mrs_pkg::kind_type  replier_kind_ff,  replier_kind_in;
   logic [15:0]        replier_port_ff,  replier_port_in;
   logic signed [10:0] replier_iface_ff, replier_iface_in;
   logic [19:0]        replier_cost_ff,  replier_cost_in;
   logic [7:0]         replier_dist_ff,  replier_dist_in;
   logic signed [31:0] upstream_addr_ff, upstream_addr_in;
   logic signed [31:0] down_addr_ff,     down_addr_in;
   logic signed [16:0] down_port_ff,     down_port_in;
   logic               have_receiver_ff, have_receiver_in;

   logic signed [31:0] own_addr_ext;
   logic signed [16:0] own_port_ext;
   logic [7:0]         hop1;
   logic               iface_local;
   logic               iface_ok;
   logic               tpif_ok;
   logic               same_iface;

   // send toward the upstream agent, error when it is unset
   function automatic mrs_pkg::rsp_fields_type go_up(
      input mrs_pkg::rsp_fields_type r,
      input logic signed [31:0]      up,
      input logic signed [31:0]      own
   );
      mrs_pkg::rsp_fields_type o;
      o = r;
      if (up[31]) begin
         o.action = mrs_pkg::ACT_ERROR;
      end else begin
         o.action    = mrs_pkg::ACT_UP;
         o.dest_addr = up;
         o.from_out  = own;
      end
      return o;
   endfunction

   // handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // derived operands
   assign own_addr_ext = {1'b0, own_address_ff};
   assign own_port_ext = {1'b0, own_port_ff};
   assign hop1         = (in_data_ff.hop_count == 8'hFF) ? 8'hFF
                                                         : in_data_ff.hop_count + 8'd1;
   assign iface_local  = in_data_ff.in_iface[10];
   assign iface_ok     = !iface_local &&
                         ({22'd0, in_data_ff.in_iface[9:0]} < 32'(IFACE_COUNT));
   assign tpif_ok      = {22'd0, in_data_ff.tp_iface} < 32'(IFACE_COUNT);
   assign same_iface   = replier_iface_ff == in_data_ff.in_iface;

   // per-packet decision and state update
   always_comb begin
      res_in               = '0;
      res_in.action        = mrs_pkg::ACT_NEXT;
      res_in.out_iface     = '1;
      res_in.dest_addr     = '1;
      res_in.dest_port     = '1;
      res_in.hop_count_out = in_data_ff.hop_count;
      res_in.ttl_out       = in_data_ff.ttl;
      res_in.from_out      = in_data_ff.path_addr;
      res_in.down_addr_out = in_data_ff.carried_down_addr;
      res_in.down_port_out = in_data_ff.carried_down_port;

      replier_kind_in  = replier_kind_ff;
      replier_port_in  = replier_port_ff;
      replier_iface_in = replier_iface_ff;
      replier_cost_in  = replier_cost_ff;
      replier_dist_in  = replier_dist_ff;
      upstream_addr_in = upstream_addr_ff;
      down_addr_in     = down_addr_ff;
      down_port_in     = down_port_ff;
      have_receiver_in = have_receiver_ff;

      if (agent_enable_ff) begin
         case (in_mode_ff)
            mrs_pkg::MODE_SRC_REFRESH: begin
               res_in.hop_count_out = hop1;
               res_in.action        = mrs_pkg::ACT_DROP;
               if (same_iface) begin
                  replier_cost_in = in_data_ff.adv_cost;
                  replier_dist_in = hop1;
               end else if (replier_cost_ff >= in_data_ff.adv_cost &&
                            replier_dist_ff > hop1) begin
                  replier_cost_in  = in_data_ff.adv_cost;
                  replier_dist_in  = hop1;
                  replier_iface_in = in_data_ff.in_iface;
                  if (iface_local) begin
                     replier_kind_in = mrs_pkg::KIND_LOCAL;
                     replier_port_in = in_data_ff.src_port;
                  end else begin
                     replier_kind_in = iface_ok ? mrs_pkg::KIND_LINK : mrs_pkg::KIND_NONE;
                  end
                  down_addr_in   = '1;
                  down_port_in   = '1;
                  res_in.ttl_out = (in_data_ff.ttl != 8'd0) ? in_data_ff.ttl - 8'd1 : 8'd0;
                  if (in_data_ff.ttl > 8'd1) begin
                     res_in.action = mrs_pkg::ACT_NEXT;
                  end
               end
            end
            mrs_pkg::MODE_REFRESH: begin
               res_in.hop_count_out = hop1;
               if (same_iface || replier_cost_ff > in_data_ff.adv_cost) begin
                  replier_cost_in  = in_data_ff.adv_cost;
                  replier_dist_in  = hop1;
                  replier_iface_in = in_data_ff.in_iface;
                  if (iface_local) begin
                     replier_kind_in  = mrs_pkg::KIND_LOCAL;
                     replier_port_in  = in_data_ff.src_port;
                     have_receiver_in = 1'b1;
                     down_addr_in     = '1;
                     down_port_in     = '1;
                  end else begin
                     down_addr_in         = in_data_ff.carried_down_addr;
                     down_port_in         = in_data_ff.carried_down_port;
                     res_in.down_addr_out = own_addr_ext;
                     res_in.down_port_out = own_port_ext;
                     replier_kind_in      = mrs_pkg::KIND_NONE;
                  end
                  res_in = go_up(res_in, upstream_addr_ff, own_addr_ext);
               end else begin
                  res_in.action = mrs_pkg::ACT_DROP;
               end
            end
            mrs_pkg::MODE_REQUEST: begin
               if (same_iface) begin
                  res_in = go_up(res_in, upstream_addr_ff, own_addr_ext);
               end else begin
                  res_in.tp_fill = (in_data_ff.tp_addr == '1);
                  if (replier_kind_ff == mrs_pkg::KIND_LOCAL) begin
                     res_in.action    = mrs_pkg::ACT_LOCAL;
                     res_in.out_iface = replier_iface_ff;
                     res_in.dest_port = {1'b0, replier_port_ff};
                  end else if (replier_kind_ff == mrs_pkg::KIND_LINK) begin
                     res_in.action    = mrs_pkg::ACT_LINK;
                     res_in.out_iface = replier_iface_ff;
                  end else if (down_addr_ff != '1 &&
                               in_data_ff.src_addr != down_addr_ff) begin
                     if (down_addr_ff[31]) begin
                        res_in.action = mrs_pkg::ACT_ERROR;
                     end else begin
                        res_in.action    = mrs_pkg::ACT_DOWN;
                        res_in.dest_addr = down_addr_ff;
                        res_in.dest_port = down_port_ff;
                        res_in.from_out  = own_addr_ext;
                     end
                  end else begin
                     res_in = go_up(res_in, upstream_addr_ff, own_addr_ext);
                  end
               end
            end
            mrs_pkg::MODE_DMCAST: begin
               if (tpif_ok) begin
                  res_in.action    = mrs_pkg::ACT_LINK;
                  res_in.out_iface = {1'b0, in_data_ff.tp_iface};
               end else begin
                  res_in.action = mrs_pkg::ACT_ERROR;
               end
            end
            mrs_pkg::MODE_LEAVE: begin
               if (same_iface) begin
                  down_addr_in     = '1;
                  down_port_in     = '1;
                  replier_kind_in  = mrs_pkg::KIND_NONE;
                  replier_cost_in  = mrs_pkg::COST_INFINITY;
                  replier_iface_in = '1;
                  res_in = go_up(res_in, upstream_addr_ff, own_addr_ext);
               end else begin
                  res_in.action = mrs_pkg::ACT_DROP;
               end
            end
            mrs_pkg::MODE_SETUP: begin
               if (iface_local) begin
                  replier_kind_in  = mrs_pkg::KIND_LOCAL;
                  replier_port_in  = in_data_ff.src_port;
                  replier_iface_in = in_data_ff.in_iface;
                  down_addr_in     = '1;
                  down_port_in     = '1;
                  replier_cost_in  = '0;
               end
               upstream_addr_in = in_data_ff.path_addr;
               res_in.from_out  = own_addr_ext;
            end
            mrs_pkg::MODE_SPM: begin
               if (upstream_addr_ff[31]) begin
                  upstream_addr_in = in_data_ff.path_addr;
                  res_in.from_out  = own_addr_ext;
               end
               res_in.action = mrs_pkg::ACT_DROP;
            end
            mrs_pkg::MODE_LINKS: begin
               res_in.tree_link = (in_data_ff.path_addr != own_addr_ext) && !have_receiver_ff;
               res_in.from_out  = own_addr_ext;
            end
            default: begin
               res_in.action = mrs_pkg::ACT_NEXT;
            end
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         agent_enable_ff <= 1'b1;
         own_address_ff  <= '0;
         own_port_ff     <= '0;
      end else if (csr_we) begin
         case (mrs_pkg::csr_index_type'(csr_index))
            mrs_pkg::CSR_AGENT_ENABLE: agent_enable_ff <= csr_wdata[0];
            mrs_pkg::CSR_OWN_ADDRESS:  own_address_ff  <= csr_wdata;
            mrs_pkg::CSR_OWN_PORT:     own_port_ff     <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= mrs_pkg::req_fields_type'(req_tdata);
         in_mode_ff <= mrs_pkg::mode_type'(req_tuser);
      end
      if (advance) begin
         out_data_ff <= res_in;
      end
   end

   // agent state, committed when a beat moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         replier_kind_ff  <= mrs_pkg::KIND_NONE;
         replier_port_ff  <= '0;
         replier_iface_ff <= '1;
         replier_cost_ff  <= mrs_pkg::COST_INFINITY;
         replier_dist_ff  <= '0;
         upstream_addr_ff <= '1;
         down_addr_ff     <= '1;
         down_port_ff     <= '1;
         have_receiver_ff <= 1'b0;
      end else if (advance) begin
         replier_kind_ff  <= replier_kind_in;
         replier_port_ff  <= replier_port_in;
         replier_iface_ff <= replier_iface_in;
         replier_cost_ff  <= replier_cost_in;
         replier_dist_ff  <= replier_dist_in;
         upstream_addr_ff <= upstream_addr_in;
         down_addr_ff     <= down_addr_in;
         down_port_ff     <= down_port_in;
         have_receiver_ff <= have_receiver_in;
      end
   end

   // checks
   `MRS_ASSERT_IMP(a_link_iface, replier_kind_ff == mrs_pkg::KIND_LINK,
      !replier_iface_ff[10], "link replier without a real interface")
   `MRS_ASSERT_IMP(a_stall_cause, !req_tready,
      in_valid_ff && out_valid_ff && !rsp_tready, "input stalled without a waiting result")
   `MRS_ASSERT_NXT(a_disabled_pass, advance && !agent_enable_ff,
      out_data_ff.action == mrs_pkg::ACT_NEXT, "disabled agent did not pass to next hop")
   `MRS_ASSERT_NXT(a_receiver_sticky, have_receiver_ff,
      have_receiver_ff, "receiver flag cleared outside reset")

endmodule
